/* design/talu_pkg.sv */
// ----------------------------------------------------------------------------
// talu_pkg
// shared types and operation codes for the thumb alu with flags
// ----------------------------------------------------------------------------
package talu_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FUNC_W = 5;

	// operation codes, thumb alu order first
	localparam logic [FUNC_W-1:0] FN_AND    = 5'd0;
	localparam logic [FUNC_W-1:0] FN_EOR    = 5'd1;
	localparam logic [FUNC_W-1:0] FN_LSL    = 5'd2;
	localparam logic [FUNC_W-1:0] FN_LSR    = 5'd3;
	localparam logic [FUNC_W-1:0] FN_ASR    = 5'd4;
	localparam logic [FUNC_W-1:0] FN_ADC    = 5'd5;
	localparam logic [FUNC_W-1:0] FN_SBC    = 5'd6;
	localparam logic [FUNC_W-1:0] FN_ROR    = 5'd7;
	localparam logic [FUNC_W-1:0] FN_TST    = 5'd8;
	localparam logic [FUNC_W-1:0] FN_NEG    = 5'd9;
	localparam logic [FUNC_W-1:0] FN_CMP    = 5'd10;
	localparam logic [FUNC_W-1:0] FN_CMN    = 5'd11;
	localparam logic [FUNC_W-1:0] FN_ORR    = 5'd12;
	localparam logic [FUNC_W-1:0] FN_MUL    = 5'd13;
	localparam logic [FUNC_W-1:0] FN_BIC    = 5'd14;
	localparam logic [FUNC_W-1:0] FN_MVN    = 5'd15;
	localparam logic [FUNC_W-1:0] FN_LSL_I  = 5'd16;
	localparam logic [FUNC_W-1:0] FN_LSR_I  = 5'd17;
	localparam logic [FUNC_W-1:0] FN_ASR_I  = 5'd18;
	localparam logic [FUNC_W-1:0] FN_ADD    = 5'd19;
	localparam logic [FUNC_W-1:0] FN_SUB    = 5'd20;
	localparam logic [FUNC_W-1:0] FN_MOV    = 5'd21;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
		logic              flag_n_in;
		logic              flag_z_in;
		logic              flag_c_in;
		logic              flag_v_in;
	} talu_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              flag_n_out;
		logic              flag_z_out;
		logic              flag_c_out;
		logic              flag_v_out;
		logic              write_dest;
	} talu_out_t;

endpackage

/* design/thumb_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// thumb_alu_with_flags
// thumb alu with barrel shifter and nzcv flag generation
// ----------------------------------------------------------------------------
// One word in gives one word out. A word is captured in an input register,
// passes once through the adder, the barrel shifter, the 32x32 multiplier
// (low half) and the logic unit, and the selected result and flags land in
// the output register, from which the result is offered. A new word can be
// taken every cycle while the output is not stalled. The multiplier is the
// longest path of that single pass. The block keeps no state between words;
// the current flags travel with each word. Both sides use valid/ready, and a
// stalled output only holds off the input once both registers are full.
module thumb_alu_with_flags (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  talu_pkg::talu_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output talu_pkg::talu_out_t out_data
);
	import talu_pkg::*;

	// input register stage
	talu_in_t  in_s1;
	logic      valid_s1;
	logic      ready_s1;

	// result register stage
	talu_out_t out_s2;
	logic      valid_s2;
	logic      ready_s2;

	// combinational results of the single pass
	talu_out_t res;

	// shifter
	logic [1:0]        sh_kind;
	logic [7:0]        sh_amt;
	logic [DATA_W-1:0] sh_res;
	logic              sh_c;
	logic [DATA_W:0]   sh_wide;
	logic [2*DATA_W-1:0] sh_rot;

	// adder
	logic [DATA_W-1:0] add_x;
	logic [DATA_W-1:0] add_y;
	logic              add_cin;
	logic [DATA_W:0]   add_sum;
	logic [DATA_W-1:0] add_res;
	logic              add_c;
	logic              add_v;

	logic [DATA_W-1:0] mul_res;

	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] b;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;
	localparam logic [7:0] AMT_FULL = 8'(DATA_W);

	// handshake: a stage takes a word when empty or when it is emptying
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			in_s1 <= in_data;
		end
		if (ready_s2 && valid_s1) begin
			out_s2 <= res;
		end
	end

	assign a = in_s1.operand_a;
	assign b = in_s1.operand_b;

	// shift kind and amount: register shifts use the low byte, immediate
	// shifts the low five bits with zero standing for 32 on lsr and asr
	always_comb begin
		sh_kind = SH_LSL;
		sh_amt  = b[7:0];
		case (in_s1.func)
			FN_LSL:   sh_kind = SH_LSL;
			FN_LSR:   sh_kind = SH_LSR;
			FN_ASR:   sh_kind = SH_ASR;
			FN_ROR:   sh_kind = SH_ROR;
			FN_LSL_I: begin
				sh_kind = SH_LSL;
				sh_amt  = {3'd0, b[4:0]};
			end
			FN_LSR_I: begin
				sh_kind = SH_LSR;
				sh_amt  = (b[4:0] == 5'd0) ? AMT_FULL : {3'd0, b[4:0]};
			end
			FN_ASR_I: begin
				sh_kind = SH_ASR;
				sh_amt  = (b[4:0] == 5'd0) ? AMT_FULL : {3'd0, b[4:0]};
			end
			default:  sh_kind = SH_LSL;
		endcase
	end

	// barrel shifter with arm carry-out rules
	always_comb begin
		sh_res  = a;
		sh_c    = in_s1.flag_c_in;
		sh_wide = '0;
		sh_rot  = {a, a} >> sh_amt[4:0];
		if (sh_amt != 8'd0) begin
			case (sh_kind)
				SH_LSL: begin
					if (sh_amt < AMT_FULL) begin
						sh_wide = {1'b0, a} << sh_amt[4:0];
						sh_res  = sh_wide[DATA_W-1:0];
						sh_c    = sh_wide[DATA_W];
					end else begin
						sh_res = '0;
						sh_c   = (sh_amt == AMT_FULL) ? a[0] : 1'b0;
					end
				end
				SH_LSR: begin
					if (sh_amt < AMT_FULL) begin
						sh_wide = {a, 1'b0} >> sh_amt[4:0];
						sh_res  = sh_wide[DATA_W:1];
						sh_c    = sh_wide[0];
					end else begin
						sh_res = '0;
						sh_c   = (sh_amt == AMT_FULL) ? a[DATA_W-1] : 1'b0;
					end
				end
				SH_ASR: begin
					if (sh_amt < AMT_FULL) begin
						sh_wide = $signed({a, 1'b0}) >>> sh_amt[4:0];
						sh_res  = sh_wide[DATA_W:1];
						sh_c    = sh_wide[0];
					end else begin
						sh_res = {DATA_W{a[DATA_W-1]}};
						sh_c   = a[DATA_W-1];
					end
				end
				SH_ROR: begin
					// a multiple of 32 leaves the value, carry from bit 31
					sh_res = sh_rot[DATA_W-1:0];
					sh_c   = sh_rot[DATA_W-1];
				end
				default: begin
					sh_res = a;
					sh_c   = in_s1.flag_c_in;
				end
			endcase
		end
	end

	// one adder for all add and subtract forms: subtract adds the inverse
	// of b, so the carry out is the arm not-borrow
	always_comb begin
		add_x   = a;
		add_y   = b;
		add_cin = 1'b0;
		case (in_s1.func)
			FN_ADC: add_cin = in_s1.flag_c_in;
			FN_SBC: begin
				add_y   = ~b;
				add_cin = in_s1.flag_c_in;
			end
			FN_NEG: begin
				add_x   = '0;
				add_y   = ~b;
				add_cin = 1'b1;
			end
			FN_CMP, FN_SUB: begin
				add_y   = ~b;
				add_cin = 1'b1;
			end
			default: add_cin = 1'b0;
		endcase
	end

	assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
	assign add_res = add_sum[DATA_W-1:0];
	assign add_c   = add_sum[DATA_W];
	assign add_v   = (~(add_x[DATA_W-1] ^ add_y[DATA_W-1])) &
		(add_x[DATA_W-1] ^ add_res[DATA_W-1]);

	// low half of the product only
	assign mul_res = a * b;

	// result and flag selection
	always_comb begin
		res.result     = '0;
		res.flag_c_out = in_s1.flag_c_in;
		res.flag_v_out = in_s1.flag_v_in;
		res.write_dest = 1'b1;
		res.flag_n_out = in_s1.flag_n_in;
		res.flag_z_out = in_s1.flag_z_in;
		case (in_s1.func)
			FN_AND:  res.result = a & b;
			FN_EOR:  res.result = a ^ b;
			FN_TST: begin
				res.result     = a & b;
				res.write_dest = 1'b0;
			end
			FN_ORR:  res.result = a | b;
			FN_MUL:  res.result = mul_res;
			FN_BIC:  res.result = a & ~b;
			FN_MVN:  res.result = ~b;
			FN_MOV:  res.result = b;
			FN_LSL, FN_LSR, FN_ASR, FN_ROR, FN_LSL_I, FN_LSR_I, FN_ASR_I: begin
				res.result     = sh_res;
				res.flag_c_out = sh_c;
			end
			FN_ADC, FN_SBC, FN_NEG, FN_ADD, FN_SUB: begin
				res.result     = add_res;
				res.flag_c_out = add_c;
				res.flag_v_out = add_v;
			end
			FN_CMP, FN_CMN: begin
				res.result     = add_res;
				res.flag_c_out = add_c;
				res.flag_v_out = add_v;
				res.write_dest = 1'b0;
			end
			default: begin
				// unused codes: zero result, flags untouched, no write
				res.result     = '0;
				res.write_dest = 1'b0;
			end
		endcase
		if (in_s1.func <= FN_MOV) begin
			res.flag_n_out = res.result[DATA_W-1];
			res.flag_z_out = (res.result == '0);
		end
	end

endmodule
